// ===== rtl/gas_pkg.sv =====
// shared types, register indexes and default sizes for the global alignment score block
package gas_pkg;

    localparam int MAX_REF_LEN_DEF = 256;
    localparam int SCORE_BITS_DEF  = 18;

    localparam int SYM_BITS  = 8;
    localparam int CFG_BITS  = 8;
    localparam int LEN_BITS  = 9;
    localparam int ROW_BITS  = 16;
    localparam int IDX_BITS  = 2;
    localparam int DATA_BITS = 9;

    localparam logic [IDX_BITS-1:0] CFG_GAP      = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_MATCH    = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_MISMATCH = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_REF_LEN  = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic signed [CFG_BITS-1:0] GAP_RESET      = -8'sd1;
    localparam logic signed [CFG_BITS-1:0] MATCH_RESET    = 8'sd1;
    localparam logic signed [CFG_BITS-1:0] MISMATCH_RESET = -8'sd1;
    localparam logic [LEN_BITS-1:0]        REF_LEN_RESET  = 9'd256;

    typedef struct packed {
        logic                valid;
        logic                new_aln;
        logic [SYM_BITS-1:0] sym;
    } wave_ctl_t;

endpackage

// ===== rtl/gas_cell.sv =====
// one column cell: holds a reference symbol and the column's previous-row score
module gas_cell #(
    parameter int SCORE_BITS = gas_pkg::SCORE_BITS_DEF,
    parameter int LEN_W      = 9,
    parameter int COL        = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   ld_en,
    input  logic [gas_pkg::SYM_BITS-1:0]           ld_pos,
    input  logic [gas_pkg::SYM_BITS-1:0]           ld_sym,
    input  logic signed [gas_pkg::CFG_BITS-1:0]    gap,
    input  logic signed [gas_pkg::CFG_BITS-1:0]    mt,
    input  logic signed [gas_pkg::CFG_BITS-1:0]    mm,
    input  logic [LEN_W-1:0]                       len_eff,
    input  gas_pkg::wave_ctl_t                     wave_in,
    input  logic signed [SCORE_BITS-1:0]           left_in,
    input  logic signed [SCORE_BITS-1:0]           diag_in,
    input  logic signed [SCORE_BITS-1:0]           bnd_in,
    output gas_pkg::wave_ctl_t                     wave_out,
    output logic signed [SCORE_BITS-1:0]           left_out,
    output logic signed [SCORE_BITS-1:0]           diag_out,
    output logic signed [SCORE_BITS-1:0]           bnd_out
);

    localparam int POS = COL - 1;
    localparam logic [LEN_W-1:0] COL_IDX = LEN_W'(COL);
    localparam logic signed [SCORE_BITS-1:0] S_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] S_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0]        x,
        input logic signed [gas_pkg::CFG_BITS-1:0] y
    );
        logic signed [SCORE_BITS:0] s;
        s = {x[SCORE_BITS-1], x} + {{(SCORE_BITS-7){y[7]}}, y};
        if (s[SCORE_BITS] != s[SCORE_BITS-1])
            return s[SCORE_BITS] ? S_MIN : S_MAX;
        return s[SCORE_BITS-1:0];
    endfunction

    logic [gas_pkg::SYM_BITS-1:0]    sym_reg;
    logic signed [SCORE_BITS-1:0]    up_reg;
    gas_pkg::wave_ctl_t              wave_reg;
    logic signed [SCORE_BITS-1:0]    left_reg;
    logic signed [SCORE_BITS-1:0]    diag_reg;
    logic signed [SCORE_BITS-1:0]    bnd_reg;

    logic                            active;
    logic                            ld_hit;
    logic signed [SCORE_BITS-1:0]    bnd_j;
    logic signed [SCORE_BITS-1:0]    up_eff;
    logic signed [gas_pkg::CFG_BITS-1:0] sub;
    logic signed [SCORE_BITS-1:0]    cand_d;
    logic signed [SCORE_BITS-1:0]    cand_u;
    logic signed [SCORE_BITS-1:0]    cand_l;
    logic signed [SCORE_BITS-1:0]    best;

    always_comb
    begin
        active = (COL_IDX <= len_eff);
        ld_hit = ld_en && (POS < 256) && (ld_pos == gas_pkg::SYM_BITS'(POS));
        bnd_j  = sat_add(bnd_in, gap);
        up_eff = wave_in.new_aln ? bnd_j : up_reg;
        sub    = (sym_reg == wave_in.sym) ? mt : mm;
        cand_d = sat_add(diag_in, sub);
        cand_u = sat_add(up_eff, gap);
        cand_l = sat_add(left_in, gap);
        best   = cand_d;
        if (cand_u > best)
            best = cand_u;
        if (cand_l > best)
            best = cand_l;
    end

    always_ff @(posedge clk)
    begin
        if (ld_hit)
            sym_reg <= ld_sym;
        if (wave_in.valid)
        begin
            if (active)
                up_reg <= best;
            else if (wave_in.new_aln)
                up_reg <= bnd_j;
            left_reg <= active ? best : left_in;
            diag_reg <= up_eff;
            bnd_reg  <= bnd_j;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_reg <= '0;
        else
            wave_reg <= wave_in;
    end

    assign wave_out = wave_reg;
    assign left_out = left_reg;
    assign diag_out = diag_reg;
    assign bnd_out  = bnd_reg;

endmodule

// ===== rtl/global_alignment_score.sv =====
// top level: configuration, row control, cell chain and result buffering
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    kind, symbol, ref_position, last
// out       output     out_valid / out_ready  row_score, row_number, last_res
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a load word does not occupy the chain; a query word occupies it until its wavefront
// has walked the cell chain one column per cycle
// reset clears control state and loads the configuration defaults; no clearing pass is needed
// a finished row waits in the output register and a second one in a skid stage,
// the input stalls only while a row is in the chain or the skid stage is full
module global_alignment_score #(
    parameter int MAX_REF_LEN = gas_pkg::MAX_REF_LEN_DEF,
    parameter int SCORE_BITS  = gas_pkg::SCORE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [gas_pkg::SYM_BITS-1:0]          symbol,
    input  logic [gas_pkg::SYM_BITS-1:0]          ref_position,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SCORE_BITS-1:0]          row_score,
    output logic [gas_pkg::ROW_BITS-1:0]          row_number,
    output logic                                  last_res,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gas_pkg::IDX_BITS-1:0]          cfg_index,
    input  logic [gas_pkg::DATA_BITS-1:0]         cfg_data
);

    localparam int LEN_W = $clog2(MAX_REF_LEN + 1);
    localparam int CMP_W = (LEN_W > gas_pkg::LEN_BITS) ? LEN_W : gas_pkg::LEN_BITS;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_REF_LEN);
    localparam logic signed [SCORE_BITS-1:0] S_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] S_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic [gas_pkg::ROW_BITS-1:0] ROW_SAT = '1;

    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0]        x,
        input logic signed [gas_pkg::CFG_BITS-1:0] y
    );
        logic signed [SCORE_BITS:0] s;
        s = {x[SCORE_BITS-1], x} + {{(SCORE_BITS-7){y[7]}}, y};
        if (s[SCORE_BITS] != s[SCORE_BITS-1])
            return s[SCORE_BITS] ? S_MIN : S_MAX;
        return s[SCORE_BITS-1:0];
    endfunction

    // configuration
    logic signed [gas_pkg::CFG_BITS-1:0] gap_reg;
    logic signed [gas_pkg::CFG_BITS-1:0] match_reg;
    logic signed [gas_pkg::CFG_BITS-1:0] mismatch_reg;
    logic [gas_pkg::LEN_BITS-1:0]        ref_len_reg;
    logic [CMP_W-1:0]                    len_ext;
    logic [LEN_W-1:0]                    len_eff;

    // row control
    logic                                busy_reg;
    logic [gas_pkg::ROW_BITS-1:0]        rows_done_reg;
    logic [gas_pkg::ROW_BITS-1:0]        rows_done_next;
    logic [gas_pkg::ROW_BITS-1:0]        row_inc;
    logic signed [SCORE_BITS-1:0]        col0_reg;
    logic [gas_pkg::ROW_BITS-1:0]        pend_row_reg;
    logic                                pend_last_reg;
    logic                                new_aln;
    logic signed [SCORE_BITS-1:0]        prev0;
    logic signed [SCORE_BITS-1:0]        col0_next;

    gas_pkg::wave_ctl_t                  start_wave_reg;
    logic signed [SCORE_BITS-1:0]        start_left_reg;
    logic signed [SCORE_BITS-1:0]        start_diag_reg;

    // chain wiring
    gas_pkg::wave_ctl_t                  wave_w [0:MAX_REF_LEN];
    logic signed [SCORE_BITS-1:0]        left_w [0:MAX_REF_LEN];
    logic signed [SCORE_BITS-1:0]        diag_w [0:MAX_REF_LEN];
    logic signed [SCORE_BITS-1:0]        bnd_w  [0:MAX_REF_LEN];

    // result buffering
    logic                                out_valid_reg;
    logic signed [SCORE_BITS-1:0]        out_score_reg;
    logic [gas_pkg::ROW_BITS-1:0]        out_row_reg;
    logic                                out_last_reg;
    logic                                skid_valid_reg;
    logic signed [SCORE_BITS-1:0]        skid_score_reg;
    logic [gas_pkg::ROW_BITS-1:0]        skid_row_reg;
    logic                                skid_last_reg;

    logic                                in_fire;
    logic                                ld_en;
    logic                                q_fire;
    logic                                end_valid;
    logic                                out_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg && !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign ld_en     = in_fire && (kind == gas_pkg::KIND_LOAD);
    assign q_fire    = in_fire && (kind == gas_pkg::KIND_QUERY);
    assign end_valid = wave_w[MAX_REF_LEN].valid;
    assign out_take  = !out_valid_reg || out_ready;

    always_comb
    begin
        len_ext   = CMP_W'(ref_len_reg);
        len_eff   = (len_ext > MAX_EXT) ? LEN_W'(MAX_EXT) : LEN_W'(len_ext);
        new_aln   = (rows_done_reg == '0);
        prev0     = new_aln ? '0 : col0_reg;
        col0_next = sat_add(prev0, gap_reg);
        row_inc   = (rows_done_reg == ROW_SAT) ? rows_done_reg : rows_done_reg + 1'b1;
        rows_done_next = last ? '0 : row_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg      <= gas_pkg::GAP_RESET;
            match_reg    <= gas_pkg::MATCH_RESET;
            mismatch_reg <= gas_pkg::MISMATCH_RESET;
            ref_len_reg  <= gas_pkg::REF_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gas_pkg::CFG_GAP:      gap_reg      <= cfg_data[gas_pkg::CFG_BITS-1:0];
                gas_pkg::CFG_MATCH:    match_reg    <= cfg_data[gas_pkg::CFG_BITS-1:0];
                gas_pkg::CFG_MISMATCH: mismatch_reg <= cfg_data[gas_pkg::CFG_BITS-1:0];
                gas_pkg::CFG_REF_LEN:  ref_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // row start and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rows_done_reg  <= '0;
            start_wave_reg <= '0;
        end
        else
        begin
            start_wave_reg.valid <= q_fire;
            if (q_fire)
            begin
                busy_reg               <= 1'b1;
                rows_done_reg          <= rows_done_next;
                start_wave_reg.new_aln <= new_aln;
                start_wave_reg.sym     <= symbol;
            end
            else if (end_valid)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_fire)
        begin
            col0_reg       <= col0_next;
            start_left_reg <= col0_next;
            start_diag_reg <= prev0;
            pend_row_reg   <= row_inc;
            pend_last_reg  <= last;
        end
    end

    assign wave_w[0] = start_wave_reg;
    assign left_w[0] = start_left_reg;
    assign diag_w[0] = start_diag_reg;
    assign bnd_w[0]  = '0;

    for (genvar k = 0; k < MAX_REF_LEN; k++)
    begin : g_cell
        gas_cell #(
            .SCORE_BITS (SCORE_BITS),
            .LEN_W      (LEN_W),
            .COL        (k + 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ld_en    (ld_en),
            .ld_pos   (ref_position),
            .ld_sym   (symbol),
            .gap      (gap_reg),
            .mt       (match_reg),
            .mm       (mismatch_reg),
            .len_eff  (len_eff),
            .wave_in  (wave_w[k]),
            .left_in  (left_w[k]),
            .diag_in  (diag_w[k]),
            .bnd_in   (bnd_w[k]),
            .wave_out (wave_w[k+1]),
            .left_out (left_w[k+1]),
            .diag_out (diag_w[k+1]),
            .bnd_out  (bnd_w[k+1])
        );
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= end_valid;
        end
        else if (end_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_score_reg <= skid_score_reg;
                out_row_reg   <= skid_row_reg;
                out_last_reg  <= skid_last_reg;
            end
            else if (end_valid)
            begin
                out_score_reg <= left_w[MAX_REF_LEN];
                out_row_reg   <= pend_row_reg;
                out_last_reg  <= pend_last_reg;
            end
        end
        else if (end_valid)
        begin
            skid_score_reg <= left_w[MAX_REF_LEN];
            skid_row_reg   <= pend_row_reg;
            skid_last_reg  <= pend_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_score  = out_score_reg;
    assign row_number = out_row_reg;
    assign last_res   = out_last_reg;

    a_end_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        end_valid |-> busy_reg)
        else $error("row finished with no row in the chain");

    a_skid_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(skid_valid_reg && end_valid))
        else $error("row finished while skid stage full");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while output is empty");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_fire |=> busy_reg && start_wave_reg.valid)
        else $error("query word did not start a wavefront");

endmodule
